// ----- design/dbgce_pkg.sv -----
package dbgce_pkg;

    localparam int MAX_CONTACTS = 1024;
    localparam int SLOT_W       = $clog2(MAX_CONTACTS);
    localparam int CNT_W        = 6;
    localparam int ROOT_STEPS   = 26;
    localparam int DIV_STEPS    = 35;
    localparam int EXP_TERMS    = 14;
    localparam int POW_STEPS    = 5;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef enum logic [0:0] {
        REG_STRENGTH = 1'b0,
        REG_WIDTH    = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic               which_map;
        logic [SLOT_W-1:0]  store_index;
        logic               has_partner;
        logic signed [23:0] atom_a_x;
        logic signed [23:0] atom_a_y;
        logic signed [23:0] atom_a_z;
        logic signed [23:0] atom_b_x;
        logic signed [23:0] atom_b_y;
        logic signed [23:0] atom_b_z;
        logic [23:0]        native_distance;
        logic               last;
    } item_t;

    typedef struct packed {
        logic signed [31:0] total_energy;
        logic               saturated;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQZ, ST_SUM, ST_ROOT, ST_DR, ST_DRSQ,
        ST_RANGE, ST_DIV, ST_EINIT, ST_EMUL, ST_EREC, ST_ECOR, ST_EDONE,
        ST_PA, ST_PB, ST_PC, ST_TERM, ST_ROUND, ST_ACC
    } state_t;

    typedef enum logic [4:0] {
        CMD_NOP, CMD_LOAD, CMD_SQX, CMD_SQY, CMD_SQZ, CMD_SUM, CMD_ROOT,
        CMD_DR, CMD_DRSQ, CMD_RANGE, CMD_DIV, CMD_EINIT, CMD_EMUL, CMD_EREC,
        CMD_ECOR, CMD_EDONE, CMD_PA, CMD_PB, CMD_PC, CMD_TERM, CMD_ROUND,
        CMD_ACC
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [CNT_W-1:0] cnt;
        logic             sel;
    } ctl_t;

    typedef struct packed {
        logic in_range;
    } stat_t;

    // floor((2^32 - 1) / n)
    function automatic logic [31:0] recip(input logic [3:0] n);
        logic [31:0] r;
        r = 32'd0;
        unique case (n)
            4'd1:    r = 32'd4294967295;
            4'd2:    r = 32'd2147483647;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741823;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870911;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            4'd13:   r = 32'd330382099;
            4'd14:   r = 32'd306783378;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/dual_basin_gaussian_contact_energy.sv -----
// Sums a dual-basin Gaussian contact energy, one contact at a time. A contact is
// taken when start is high and busy is low; it then occupies the block through the
// 26-step square root, the 35-step divider and the two 14-term exponential series
// (the last two skipped when (r-d)^2/(2*ksi) reaches 32 and the term is zero); the
// series share one 32x32 multiplier with the squaring and power steps. A contact with
// last set leaves its total on result for one cycle with done high as busy falls; there
// is no back-pressure, so capture it then. Write registers only while busy is low.
module dual_basin_gaussian_contact_energy
    import dbgce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    ctl_t  ctl;
    stat_t stat;

    assign cfg_ready = ~busy;

    dbgce_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .ctl   (ctl)
    );

    dbgce_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .item      (item),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

// ----- design/dbgce_ctrl.sv -----
module dbgce_ctrl
    import dbgce_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output logic  busy,
    output ctl_t  ctl
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        ctl.cmd    = CMD_NOP;
        ctl.cnt    = cnt_reg;
        ctl.sel    = sel_reg;
        busy       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.cmd    = CMD_LOAD;
                    state_next = ST_SQX;
                end
            end
            ST_SQX:  begin ctl.cmd = CMD_SQX; state_next = ST_SQY; end
            ST_SQY:  begin ctl.cmd = CMD_SQY; state_next = ST_SQZ; end
            ST_SQZ:  begin ctl.cmd = CMD_SQZ; state_next = ST_SUM; end
            ST_SUM:
            begin
                ctl.cmd    = CMD_SUM;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                ctl.cmd  = CMD_ROOT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                    state_next = ST_DR;
            end
            ST_DR:   begin ctl.cmd = CMD_DR;   state_next = ST_DRSQ; end
            ST_DRSQ: begin ctl.cmd = CMD_DRSQ; state_next = ST_RANGE; end
            ST_RANGE:
            begin
                ctl.cmd  = CMD_RANGE;
                cnt_next = '0;
                sel_next = 1'b0;
                state_next = stat.in_range ? ST_DIV : ST_TERM;
            end
            ST_DIV:
            begin
                ctl.cmd  = CMD_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_EINIT;
            end
            ST_EINIT:
            begin
                ctl.cmd    = CMD_EINIT;
                cnt_next   = CNT_W'(EXP_TERMS);
                state_next = ST_EMUL;
            end
            ST_EMUL: begin ctl.cmd = CMD_EMUL; state_next = ST_EREC; end
            ST_EREC: begin ctl.cmd = CMD_EREC; state_next = ST_ECOR; end
            ST_ECOR:
            begin
                ctl.cmd  = CMD_ECOR;
                cnt_next = cnt_reg - 1'b1;
                state_next = (cnt_reg == CNT_W'(1)) ? ST_EDONE : ST_EMUL;
            end
            ST_EDONE:
            begin
                ctl.cmd = CMD_EDONE;
                if (!sel_reg)
                begin
                    // exp(-1) done, now the fractional part
                    sel_next   = 1'b1;
                    state_next = ST_EINIT;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_PA;
                end
            end
            ST_PA: begin ctl.cmd = CMD_PA; state_next = ST_PB; end
            ST_PB: begin ctl.cmd = CMD_PB; state_next = ST_PC; end
            ST_PC:
            begin
                ctl.cmd  = CMD_PC;
                cnt_next = cnt_reg + 1'b1;
                state_next = (cnt_reg == CNT_W'(POW_STEPS - 1)) ? ST_TERM : ST_PA;
            end
            ST_TERM:  begin ctl.cmd = CMD_TERM;  state_next = ST_ROUND; end
            ST_ROUND: begin ctl.cmd = CMD_ROUND; state_next = ST_ACC; end
            ST_ACC:   begin ctl.cmd = CMD_ACC;   state_next = ST_IDLE; end
            default:  state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- design/dbgce_datapath.sv -----
module dbgce_datapath
    import dbgce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output stat_t       stat,
    output logic        done,
    output result_t     result
);

    logic [15:0]        lambda_reg, ksi_reg;
    item_t              item_reg;
    logic signed [31:0] mem [MAX_CONTACTS];
    logic signed [31:0] stored_reg;
    logic [63:0]        prod_reg;
    logic [49:0]        r2_reg;
    logic [51:0]        rem_reg, root_reg, bit_reg;
    logic [25:0]        adr_reg;
    logic [15:0]        drem_reg;
    logic [34:0]        dvd_reg, q_reg;
    logic [30:0]        acc_reg, p_reg, pw_reg, res_reg;
    logic [20:0]        mag_reg;
    logic signed [31:0] energy_reg;
    logic               sat_reg, done_reg;
    result_t            result_reg;

    logic [31:0]        mul_a, mul_b;
    logic signed [24:0] dx, dy, dz;
    logic [24:0]        adx, ady, adz;
    logic [15:0]        k;
    logic [51:0]        root_try;
    logic signed [26:0] dr;
    logic [16:0]        rem2, rem2_sub;
    logic               ge;
    logic [30:0]        fop, q0;
    logic [34:0]        qn, rcor;
    logic [3:0]         n;
    logic signed [31:0] term;
    logic signed [32:0] delta;
    logic signed [33:0] sum;
    logic signed [31:0] sum_sat;
    logic               clamp;

    assign k  = (ksi_reg == 16'd0) ? 16'd1 : ksi_reg;
    assign dx = 25'(item_reg.atom_a_x) - 25'(item_reg.atom_b_x);
    assign dy = 25'(item_reg.atom_a_y) - 25'(item_reg.atom_b_y);
    assign dz = 25'(item_reg.atom_a_z) - 25'(item_reg.atom_b_z);
    assign adx = dx[24] ? 25'(-dx) : 25'(dx);
    assign ady = dy[24] ? 25'(-dy) : 25'(dy);
    assign adz = dz[24] ? 25'(-dz) : 25'(dz);
    assign root_try = root_reg + bit_reg;
    assign dr = $signed({1'b0, root_reg[25:0]}) - $signed({3'b000, item_reg.native_distance});
    assign rem2 = {drem_reg, dvd_reg[34]};
    assign ge = (rem2 >= {1'b0, k});
    assign rem2_sub = rem2 - {1'b0, k};
    assign fop = ctl.sel ? {1'b0, q_reg[29:0]} : ONE_Q30;
    assign n = ctl.cnt[3:0];
    assign q0 = prod_reg[62:32];
    assign qn = 35'(q0) * 35'(n);
    assign rcor = 35'(p_reg) - qn;
    assign term = -$signed({11'd0, mag_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctl.cmd)
            CMD_SQX:  begin mul_a = 32'(adx); mul_b = 32'(adx); end
            CMD_SQY:  begin mul_a = 32'(ady); mul_b = 32'(ady); end
            CMD_SQZ:  begin mul_a = 32'(adz); mul_b = 32'(adz); end
            CMD_DRSQ: begin mul_a = 32'(adr_reg); mul_b = 32'(adr_reg); end
            CMD_EMUL: begin mul_a = 32'(fop); mul_b = 32'(acc_reg); end
            CMD_EREC: begin mul_a = 32'(prod_reg[60:30]); mul_b = recip(n); end
            CMD_PA:   begin mul_a = 32'(res_reg); mul_b = 32'(pw_reg); end
            CMD_PB:   begin mul_a = 32'(pw_reg); mul_b = 32'(pw_reg); end
            CMD_TERM: begin mul_a = 32'(lambda_reg); mul_b = 32'(res_reg); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        delta = 33'(term);
        if (item_reg.which_map && item_reg.has_partner)
            delta = 33'(term < stored_reg ? term : stored_reg) - 33'(stored_reg);
        sum = 34'(energy_reg) + 34'(delta);
        clamp = 1'b0;
        sum_sat = sum[31:0];
        if (sum > 34'sd2147483647)
        begin
            sum_sat = 32'sh7FFF_FFFF;
            clamp   = 1'b1;
        end
        else if (sum < -34'sd2147483648)
        begin
            sum_sat = 32'sh8000_0000;
            clamp   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_reg <= 16'd0;
            ksi_reg    <= 16'd256;
            energy_reg <= '0;
            sat_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == REG_STRENGTH)
                    lambda_reg <= cfg_data;
                else
                    ksi_reg <= cfg_data;
            end
            if (ctl.cmd == CMD_ACC)
            begin
                if (item_reg.last)
                begin
                    energy_reg <= '0;
                    sat_reg    <= 1'b0;
                    done_reg   <= 1'b1;
                end
                else
                begin
                    energy_reg <= sum_sat;
                    sat_reg    <= sat_reg | clamp;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        if (ctl.cmd == CMD_ACC)
        begin
            result_reg.total_energy <= sum_sat;
            result_reg.saturated    <= sat_reg | clamp;
        end
        unique case (ctl.cmd)
            CMD_LOAD: item_reg <= item;
            CMD_SQX:  stored_reg <= mem[item_reg.store_index];
            CMD_SQY:  r2_reg <= prod_reg[49:0];
            CMD_SQZ:  r2_reg <= r2_reg + prod_reg[49:0];
            CMD_SUM:
            begin
                rem_reg  <= 52'(r2_reg) + 52'(prod_reg[49:0]);
                root_reg <= '0;
                bit_reg  <= 52'(1) << 50;
            end
            CMD_ROOT:
            begin
                if (rem_reg >= root_try)
                begin
                    rem_reg  <= rem_reg - root_try;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            CMD_DR: adr_reg <= dr[26] ? 26'(-dr) : 26'(dr);
            CMD_RANGE:
            begin
                drem_reg <= prod_reg[37:22];
                dvd_reg  <= {prod_reg[21:0], 13'd0};
                q_reg    <= '0;
                if (!stat.in_range)
                    res_reg <= '0;
            end
            CMD_DIV:
            begin
                drem_reg <= ge ? rem2_sub[15:0] : rem2[15:0];
                dvd_reg  <= dvd_reg << 1;
                q_reg    <= {q_reg[33:0], ge};
            end
            CMD_EINIT: acc_reg <= ONE_Q30;
            CMD_EREC:  p_reg <= prod_reg[60:30];
            CMD_ECOR:  acc_reg <= ONE_Q30 - (q0 + 31'(rcor >= 35'(n)));
            CMD_EDONE:
            begin
                if (ctl.sel)
                    res_reg <= acc_reg;
                else
                    pw_reg <= acc_reg;
            end
            CMD_PB:
            begin
                if (q_reg[30 + 32'(ctl.cnt[2:0])])
                    res_reg <= prod_reg[60:30];
            end
            CMD_PC:    pw_reg <= prod_reg[60:30];
            CMD_ROUND: mag_reg <= 21'((prod_reg[47:0] + (48'd1 << 25)) >> 26);
            CMD_ACC:
            begin
                if (!item_reg.which_map)
                    mem[item_reg.store_index] <= term;
                else if (item_reg.has_partner)
                    mem[item_reg.store_index] <= '0;
            end
            default: ;
        endcase
    end

    // out of range when (r-d)^2 >= ksi * 2^22, i.e. x >= 32
    assign stat.in_range = (prod_reg[51:0] < {14'd0, k, 22'd0});
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- tb/tb.sv -----
module tb;
    import dbgce_pkg::*;

    localparam int           SLOTS     = MAX_CONTACTS;
    localparam int           ITEM_W    = $bits(item_t);
    localparam int           SETTLE    = 200;
    localparam longint       MAX_CYCLE = 3_000_000;
    localparam longint unsigned Q30    = 64'd1 << 30;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    dual_basin_gaussian_contact_energy u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state
    logic [15:0]    strength;
    logic [15:0]    width;
    longint         slot_energy [SLOTS];
    bit             slot_written [SLOTS];
    int             written_list [$];
    longint         energy_sum;
    bit             sum_clamped;
    result_t        totals_due [$];

    int             errors;
    int             contacts_sent;
    int             totals_seen;
    int             clamped_seen;
    longint         cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLE)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("dual_basin_gaussian_contact_energy test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            totals_seen++;
            if (totals_due.size() == 0)
                report_mismatch("unexpected total", result.total_energy, 0);
            else
            begin
                want = totals_due.pop_front();
                if (result.total_energy !== want.total_energy)
                    report_mismatch("total_energy", result.total_energy, want.total_energy);
                if (result.saturated !== want.saturated)
                    report_mismatch("saturated", result.saturated, want.saturated);
                if (want.saturated)
                    clamped_seen++;
            end
        end
    end

    function automatic longint unsigned bit_root(input longint unsigned n);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned b;
        rem  = n;
        root = 0;
        b    = 64'd1 << 50;
        for (int k = 0; k < 26; k++)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // exp(-f) for f in Q0.30, Horner with truncation
    function automatic longint unsigned decay_series(input longint unsigned f);
        longint unsigned acc;
        acc = Q30;
        for (int n = 14; n >= 1; n--)
            acc = Q30 - ((f * acc) >> 30) / n;
        return acc;
    endfunction

    function automatic longint well_term(input item_t it);
        longint          dx, dy, dz, dr;
        longint unsigned r2, adr, dr2, k, x, ip, pw, res, e;
        dx  = longint'(it.atom_a_x) - longint'(it.atom_b_x);
        dy  = longint'(it.atom_a_y) - longint'(it.atom_b_y);
        dz  = longint'(it.atom_a_z) - longint'(it.atom_b_z);
        r2  = dx * dx + dy * dy + dz * dz;
        dr  = longint'(bit_root(r2)) - longint'({40'd0, it.native_distance});
        adr = dr < 0 ? -dr : dr;
        dr2 = adr * adr;
        k   = (width == 0) ? 1 : width;
        e   = 0;
        if (dr2 < (k << 22))
        begin
            x   = (dr2 << 13) / k;
            ip  = x >> 30;
            pw  = decay_series(Q30);
            res = decay_series(x & (Q30 - 1));
            for (int b = 0; b < 5; b++)
            begin
                if ((ip >> b) & 1)
                    res = (res * pw) >> 30;
                pw = (pw * pw) >> 30;
            end
            e = res;
        end
        return -longint'((longint'(strength) * e + (64'd1 << 25)) >> 26);
    endfunction

    function automatic void add_energy(input longint delta);
        longint s;
        s = energy_sum + delta;
        if (s > 64'sd2147483647)
        begin
            s = 64'sd2147483647;
            sum_clamped = 1'b1;
        end
        else if (s < -64'sd2147483648)
        begin
            s = -64'sd2147483648;
            sum_clamped = 1'b1;
        end
        energy_sum = s;
    endfunction

    function automatic void apply_contact(input item_t it);
        longint  term, held, m;
        result_t r;
        term = well_term(it);
        if (!it.which_map)
        begin
            slot_energy[it.store_index] = term;
            if (!slot_written[it.store_index])
                written_list.push_back(it.store_index);
            slot_written[it.store_index] = 1'b1;
            add_energy(term);
        end
        else if (it.has_partner)
        begin
            held = slot_energy[it.store_index];
            m    = term < held ? term : held;
            add_energy(m - held);
            slot_energy[it.store_index] = 0;
        end
        else
            add_energy(term);
        if (it.last)
        begin
            r.total_energy = energy_sum[31:0];
            r.saturated    = sum_clamped;
            totals_due.push_back(r);
            energy_sum  = 0;
            sum_clamped = 1'b0;
        end
    endfunction

    // start stays high after the transfer; idle_for lowers it
    task automatic send_contact(input item_t it);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        apply_contact(it);
        contacts_sent++;
    endtask

    task automatic idle_for(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic drain();
        idle_for(1);
        while (totals_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_STRENGTH)
            strength = val;
        else
            width = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic item_t make_contact(input bit map, input int idx, input bit partner,
                                           input int ax, input int ay, input int az,
                                           input int bx, input int by, input int bz,
                                           input int d, input bit fin);
        item_t it;
        it.which_map       = map;
        it.store_index     = 10'(idx);
        it.has_partner     = partner;
        it.atom_a_x        = 24'(ax);
        it.atom_a_y        = 24'(ay);
        it.atom_a_z        = 24'(az);
        it.atom_b_x        = 24'(bx);
        it.atom_b_y        = 24'(by);
        it.atom_b_z        = 24'(bz);
        it.native_distance = 24'(d);
        it.last            = fin;
        return it;
    endfunction

    task automatic test_reset_defaults();
        // zero strength after reset: every total is zero
        send_contact(make_contact(0, 5, 0, 0, 0, 0, 4096, 0, 0, 4096, 0));
        send_contact(make_contact(1, 5, 1, 100, -100, 7, 0, 0, 0, 0, 1));
        drain();
    endtask

    task automatic test_directed();
        write_reg(REG_STRENGTH, 16'hFFFF);
        write_reg(REG_WIDTH, 16'd256);
        send_contact(make_contact(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_contact(make_contact(0, 1023, 0, 8388607, 8388607, 8388607,
                                  -8388608, -8388608, -8388608, 0, 0));
        send_contact(make_contact(0, 1, 0, -8388608, -8388608, -8388608,
                                  -8388608, -8388608, -8388608, 16777215, 0));
        send_contact(make_contact(0, 2, 0, 4096, 0, 0, 0, 0, 0, 6000, 0));
        send_contact(make_contact(1, 2, 1, 4096, 0, 0, 0, 0, 0, 4096, 0));
        send_contact(make_contact(1, 2, 1, 4096, 0, 0, 0, 0, 0, 4096, 0));
        send_contact(make_contact(1, 0, 1, 8000, 0, 0, 0, 0, 0, 0, 0));
        send_contact(make_contact(1, 1023, 1, 1, 2, 3, 1, 2, 3, 0, 0));
        send_contact(make_contact(1, 700, 0, 12288, 16384, 0, 0, 0, 0, 20480, 1));
        drain();
        // zero width treated as the smallest code
        write_reg(REG_WIDTH, 16'd0);
        send_contact(make_contact(0, 3, 0, 0, 0, 0, 300, 400, 0, 0, 0));
        send_contact(make_contact(1, 3, 1, 0, 0, 0, 1000, 0, 0, 980, 0));
        send_contact(make_contact(1, 9, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        drain();
        write_reg(REG_WIDTH, 16'hFFFF);
        write_reg(REG_STRENGTH, 16'd1);
        send_contact(make_contact(0, 4, 0, -4096, 0, 0, 4096, 0, 0, 0, 0));
        send_contact(make_contact(1, 4, 0, 0, 0, 0, 0, 0, 0, 16777215, 1));
        drain();
    endtask

    function automatic item_t rand_contact();
        item_t it;
        int    base;
        it = item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom}));
        it.last = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) != 0)
        begin
            // nearby atoms and a plausible native distance
            base = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            it.atom_a_x = 24'(base);
            it.atom_b_x = 24'(base + $signed($urandom_range(0, 1 << 15)) - (1 << 14));
            base = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            it.atom_a_y = 24'(base);
            it.atom_b_y = 24'(base + $signed($urandom_range(0, 1 << 15)) - (1 << 14));
            base = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            it.atom_a_z = 24'(base);
            it.atom_b_z = 24'(base + $signed($urandom_range(0, 1 << 15)) - (1 << 14));
            it.native_distance = 24'($urandom_range(0, 1 << 16));
        end
        if (it.which_map && it.has_partner)
        begin
            // never read a slot that was never written
            if (written_list.size() == 0)
                it.has_partner = 1'b0;
            else
                it.store_index = 10'(written_list[$urandom_range(0, written_list.size() - 1)]);
        end
        return it;
    endfunction

    task automatic test_random();
        logic [15:0] lam [5] = '{16'hFFFF, 16'd256, 16'd0, 16'd4000, 16'h8000};
        logic [15:0] wid [5] = '{16'd1, 16'hFFFF, 16'd256, 16'd4096, 16'd0};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_STRENGTH, ph < 5 ? lam[ph] : 16'($urandom));
            write_reg(REG_WIDTH, ph < 5 ? wid[ph] : 16'($urandom_range(1, 65535)));
            for (int i = 0; i < 100; i++)
            begin
                send_contact(rand_contact());
                // one burst per phase without any gaps
                if (i >= 50 || i < 20)
                    idle_for(pick_gap());
                if (i == 70)
                begin
                    idle_for(1);
                    while (totals_due.size() != 0)
                        @(posedge clk);
                end
            end
            send_contact(make_contact(1, 0, 0, $urandom, 0, 0, 0, 0, 0, $urandom, 1));
            drain();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_STRENGTH;
        cfg_data  = '0;
        cycles    = 0;
        errors    = 0;
        contacts_sent = 0;
        totals_seen   = 0;
        clamped_seen  = 0;
        strength    = 16'd0;
        width       = 16'd256;
        energy_sum  = 0;
        sum_clamped = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_energy[i]  = 0;
            slot_written[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_random();

        $display("covered %0d contacts and %0d totals, %0d of them clamped,",
                 contacts_sent, totals_seen, clamped_seen);
        $display("over both maps, partner minimum, zero and extreme register settings");
        if (errors == 0)
            $display("dual_basin_gaussian_contact_energy test passed");
        else
            $display("dual_basin_gaussian_contact_energy test failed");
        $finish;
    end

endmodule
